FILE: design/vst_pkg.sv
package vst_pkg;

   localparam int LINE_UNITS   = 400;
   localparam int TOTAL_LINES  = 525;
   localparam int ACTIVE_LINES = 480;
   localparam int ACTIVE_UNITS = 320;
   localparam int BUFFER_ROWS  = 240;

   localparam int ROW_BYTES = ACTIVE_UNITS / 2;
   localparam int FB_BYTES  = BUFFER_ROWS * ROW_BYTES;

   localparam int UNIT_W   = 9;
   localparam int LINE_W   = 10;
   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W    = 10;

   localparam logic [UNIT_W-1:0] HSYNC_START_RST = UNIT_W'(328);
   localparam logic [UNIT_W-1:0] HSYNC_WIDTH_RST = UNIT_W'(48);
   localparam logic [LINE_W-1:0] VSYNC_START_RST = LINE_W'(490);
   localparam logic [LINE_W-1:0] VSYNC_LINES_RST = LINE_W'(2);

   typedef enum logic {
      MODE_ADVANCE = 1'b0,
      MODE_WRITE   = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HSYNC_START = 2'd0,
      CSR_HSYNC_WIDTH = 2'd1,
      CSR_VSYNC_START = 2'd2,
      CSR_VSYNC_LINES = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic active;
      logic odd;
      logic hsync_n;
      logic vsync_n;
      logic last;
   } scan_type;

   function automatic logic [5:0] palette6(input logic [3:0] nib);
      logic [5:0] c;
      unique case (nib)
         4'h0: c = 6'h00;
         4'h1: c = 6'h02;
         4'h2: c = 6'h20;
         4'h3: c = 6'h22;
         4'h4: c = 6'h08;
         4'h5: c = 6'h0A;
         4'h6: c = 6'h28;
         4'h7: c = 6'h2A;
         4'h8: c = 6'h00;
         4'h9: c = 6'h03;
         4'hA: c = 6'h30;
         4'hB: c = 6'h33;
         4'hC: c = 6'h0C;
         4'hD: c = 6'h0F;
         4'hE: c = 6'h3C;
         4'hF: c = 6'h3F;
         default: c = 6'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: design/vst_ram.sv
module vst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/vga_scanout_timing_palette.sv
// channel | ports  | payload
// in      | req_*  | tdata: fb_address, fb_data; tuser: mode
// out     | rsp_*  | tdata: pin_byte; tlast: frame_last
// config  | csr_*  | index 0..3, data up to 10 bits
// one item per cycle while the output is not stalled; an advance item's pin byte passes through
// the frame buffer's registered read and then the output register
// after reset the frame buffer's 38400 bytes are cleared one byte a cycle,
// with req_tready low; config writes are taken throughout
// a stalled output holds the pipeline; write items produce no output
module vga_scanout_timing_palette (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // fb_address[15:0], fb_data[23:16]
   input  logic                              req_tuser,   // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // pin_byte
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [vst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vst_pkg::CSR_W-1:0]         csr_wdata
);
   import vst_pkg::*;

   logic [UNIT_W-1:0] hs_start_ff, hs_width_ff;
   logic [LINE_W-1:0] vs_start_ff, vs_lines_ff;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              s1_valid_ff, s1_valid_in;
   scan_type          s1_ff, s1_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        pin_ff, pin_in;
   logic              last_ff, last_in;

   logic              accept, adv, wr, out_move, s1_move;
   logic [ADDR_W-1:0] fb_address, rd_addr, ram_waddr;
   logic [DATA_W-1:0] fb_data, ram_wdata, ram_rdata;
   logic              ram_we;
   logic [LINE_W-2:0] row;
   logic [UNIT_W-1:0] hs_off;
   logic [LINE_W-1:0] vs_off;
   logic [3:0]        nib;

   assign fb_address = req_tdata[ADDR_W-1:0];
   assign fb_data    = req_tdata[ADDR_W +: DATA_W];

   assign out_move   = !out_valid_ff || rsp_tready;
   assign s1_move    = !s1_valid_ff || out_move;
   assign req_tready = !clearing_ff && s1_move;
   assign accept     = req_tvalid && req_tready;
   assign adv        = accept && (mode_type'(req_tuser) == MODE_ADVANCE);
   assign wr         = accept && (mode_type'(req_tuser) == MODE_WRITE);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hs_start_ff <= HSYNC_START_RST;
         hs_width_ff <= HSYNC_WIDTH_RST;
         vs_start_ff <= VSYNC_START_RST;
         vs_lines_ff <= VSYNC_LINES_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_HSYNC_START: hs_start_ff <= csr_wdata[UNIT_W-1:0];
            CSR_HSYNC_WIDTH: hs_width_ff <= csr_wdata[UNIT_W-1:0];
            CSR_VSYNC_START: vs_start_ff <= csr_wdata[LINE_W-1:0];
            CSR_VSYNC_LINES: vs_lines_ff <= csr_wdata[LINE_W-1:0];
            default: ;
         endcase
      end
   end

   // frame buffer clear sweep
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(FB_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign ram_we    = clearing_ff || (wr && (fb_address < ADDR_W'(FB_BYTES)));
   assign ram_waddr = clearing_ff ? clr_addr_ff : fb_address;
   assign ram_wdata = clearing_ff ? '0 : fb_data;

   assign row     = line_ff[LINE_W-1:1];
   assign rd_addr = ADDR_W'(row * ROW_BYTES) + ADDR_W'(unit_ff[UNIT_W-1:1]);

   vst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FB_BYTES)
   ) u_fb (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (adv),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // scan counters and timing
   assign hs_off = unit_ff - hs_start_ff;
   assign vs_off = line_ff - vs_start_ff;

   always_comb begin
      unit_in = unit_ff;
      line_in = line_ff;
      if (adv) begin
         if (unit_ff == UNIT_W'(LINE_UNITS - 1)) begin
            unit_in = '0;
            if (line_ff == LINE_W'(TOTAL_LINES - 1)) begin
               line_in = '0;
            end else begin
               line_in = line_ff + 1'b1;
            end
         end else begin
            unit_in = unit_ff + 1'b1;
         end
      end
      s1_in.active  = (line_ff < LINE_W'(ACTIVE_LINES)) && (unit_ff < UNIT_W'(ACTIVE_UNITS));
      s1_in.odd     = unit_ff[0];
      s1_in.hsync_n = !((unit_ff >= hs_start_ff) && (hs_off < hs_width_ff));
      s1_in.vsync_n = !((line_ff >= vs_start_ff) && (vs_off < vs_lines_ff));
      s1_in.last    = (unit_ff == UNIT_W'(LINE_UNITS - 1)) &&
                      (line_ff == LINE_W'(TOTAL_LINES - 1));
      s1_valid_in   = s1_move ? adv : s1_valid_ff;
   end

   // output stage
   assign nib = s1_ff.odd ? ram_rdata[7:4] : ram_rdata[3:0];

   always_comb begin
      out_valid_in = out_valid_ff;
      pin_in       = pin_ff;
      last_in      = last_ff;
      if (out_move) begin
         out_valid_in = s1_valid_ff;
         pin_in       = {s1_ff.vsync_n, s1_ff.hsync_n,
                         s1_ff.active ? palette6(nib) : 6'h00};
         last_in      = s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff      <= '0;
         line_ff      <= '0;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         unit_ff      <= unit_in;
         line_ff      <= line_in;
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
      pin_ff  <= pin_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = pin_ff;
   assign rsp_tlast  = last_ff;

endmodule
